/* hdl/uvs_pkg.sv */
// Shared types, constants and helper functions for the UV sphere generator.
// Used by the divider cell, the rotation cell and the top level; no dependencies.
package uvs_pkg;

	// Tessellation limits and pipeline geometry.
	localparam int MAX_TESS     = 64;
	localparam int MIN_TESS     = 3;
	localparam int DIV_STEPS    = 40;
	localparam int CORDIC_STEPS = 24;
	localparam int POST_STAGES  = 3;
	localparam int PIPE_DEPTH   = DIV_STEPS + CORDIC_STEPS + POST_STAGES;
	localparam int DIV_LANES    = 4;
	localparam int QUAD_SLOTS   = 6;

	// Divider lanes.
	localparam int LANE_RING = 0;
	localparam int LANE_SEG  = 1;
	localparam int LANE_TEXU = 2;
	localparam int LANE_TEXV = 3;

	// Gain-compensated unit vector length, Q2.30.
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

	typedef enum logic {
		CMD_VERTEX = 1'b0,
		CMD_QUAD   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DIAMETER = 2'd0,
		REG_TESS     = 2'd1,
		REG_BASE     = 2'd2,
		REG_XFORM    = 2'd3
	} reg_idx_t;

	// Partial remainder and dividend/quotient shift word of one divider lane.
	typedef struct packed {
		logic [7:0]  rem;
		logic [39:0] num;
	} div_t;

	// Rotation state of one CORDIC lane, Q2.30 and binary angle.
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
	} rot_t;

	// Side information that travels alongside the arithmetic.
	typedef struct packed {
		cmd_t        cmd;
		logic [6:0]  ring;
		logic [7:0]  segment;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic        flip_lat;
		logic        flip_lon;
	} side_t;

	// Arctangent of 2^-step as a binary angle.
	function automatic logic signed [32:0] atan_of(input logic [4:0] step);
		logic signed [32:0] a;
		case (step)
			5'd0:  a = 33'sd536870912;
			5'd1:  a = 33'sd316933406;
			5'd2:  a = 33'sd167458907;
			5'd3:  a = 33'sd85004756;
			5'd4:  a = 33'sd42667331;
			5'd5:  a = 33'sd21354465;
			5'd6:  a = 33'sd10679838;
			5'd7:  a = 33'sd5340245;
			5'd8:  a = 33'sd2670163;
			5'd9:  a = 33'sd1335087;
			5'd10: a = 33'sd667544;
			5'd11: a = 33'sd333772;
			5'd12: a = 33'sd166886;
			5'd13: a = 33'sd83443;
			5'd14: a = 33'sd41722;
			5'd15: a = 33'sd20861;
			5'd16: a = 33'sd10430;
			5'd17: a = 33'sd5215;
			5'd18: a = 33'sd2608;
			5'd19: a = 33'sd1304;
			5'd20: a = 33'sd652;
			5'd21: a = 33'sd326;
			5'd22: a = 33'sd163;
			5'd23: a = 33'sd81;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Round a Q2.30 value to Q1.15 with saturation.
	function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
		logic signed [34:0] r;
		logic signed [15:0] q;
		r = (v + 35'sd16384) >>> 15;
		if (r > 35'sd32767) begin
			q = 16'sh7fff;
		end else if (r < -35'sd32768) begin
			q = 16'sh8000;
		end else begin
			q = r[15:0];
		end
		return q;
	endfunction

	// Round a normal times diameter product to Q8.16 with saturation.
	function automatic logic signed [24:0] pos_sat(input logic signed [57:0] p);
		logic signed [57:0] r;
		logic signed [24:0] q;
		r = (p + 58'sd1073741824) >>> 31;
		if (r > 58'sd16777215) begin
			q = 25'sh0ffffff;
		end else if (r < -58'sd16777216) begin
			q = 25'sh1000000;
		end else begin
			q = r[24:0];
		end
		return q;
	endfunction

endpackage

/* hdl/uvs_div_cell.sv */
// One restoring division step: a single quotient bit per cell.
// Depends on uvs_pkg for the lane word type.
module uvs_div_cell (
	input  logic          clk,
	input  logic          en,
	input  logic [7:0]    divisor,
	input  uvs_pkg::div_t div_in,
	output uvs_pkg::div_t div_out
);
	import uvs_pkg::*;

	logic [8:0] shifted;
	logic [8:0] diff;
	logic       ge;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {div_in.rem, div_in.num[39]};
		diff    = shifted - {1'b0, divisor};
		ge      = (shifted >= {1'b0, divisor});
	end

	// Hand the updated word to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			div_out.rem <= ge ? diff[7:0] : shifted[7:0];
			div_out.num <= {div_in.num[38:0], ge};
		end
	end

endmodule

/* hdl/uvs_cordic_cell.sv */
// One rotation-mode CORDIC micro-rotation for a fixed step index.
// Depends on uvs_pkg for the rotation state type and the arctangent table.
module uvs_cordic_cell (
	input  logic          clk,
	input  logic          en,
	input  logic [4:0]    step,
	input  uvs_pkg::rot_t rot_in,
	output uvs_pkg::rot_t rot_out
);
	import uvs_pkg::*;

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] at;
	logic signed [32:0] xn;
	logic signed [32:0] yn;
	logic signed [32:0] zn;

	// Rotate towards zero residual angle.
	always_comb begin
		dx = $signed(rot_in.y) >>> step;
		dy = $signed(rot_in.x) >>> step;
		at = atan_of(step);
		if (!rot_in.z[32]) begin
			xn = $signed(rot_in.x) - dx;
			yn = $signed(rot_in.y) + dy;
			zn = $signed(rot_in.z) - at;
		end else begin
			xn = $signed(rot_in.x) + dx;
			yn = $signed(rot_in.y) - dy;
			zn = $signed(rot_in.z) + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_out.x <= xn;
			rot_out.y <= yn;
			rot_out.z <= zn;
		end
	end

endmodule

/* hdl/uv_sphere_vertex_index_generator.sv */
// Top level of the UV sphere vertex and index generator.
// Depends on uvs_pkg, uvs_div_cell and uvs_cordic_cell.
//
// Channel  | Handshake                  | Payload
// item     | item_valid / item_stall    | command, ring, segment
// result   | result_valid / result_stall| pos_*, nrm_*, tan_*, tex_*, index_value, last
// config   | cfg_write                  | cfg_index, cfg_data
//
// An item passes 40 divider cells, 24 rotation cells and 3 product stages, then the
// output register. A vertex item leaves one result per cycle while result_stall is low;
// a quad item holds the output register for six transfers, and the pipe moves on while
// the output register or the pipe tail is free.
// Items out of range or with a bad tessellation are taken and give no result.
// Reset clears the pipe's valid bits and loads the register defaults; there is no clearing pass.
module uv_sphere_vertex_index_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               command,
	input  logic [6:0]         ring,
	input  logic [7:0]         segment,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic signed [24:0] pos_z,
	output logic signed [15:0] nrm_x,
	output logic signed [15:0] nrm_y,
	output logic signed [15:0] nrm_z,
	output logic signed [15:0] tan_x,
	output logic signed [15:0] tan_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [31:0]        index_value,
	output logic               last
);
	import uvs_pkg::*;

	// Configuration registers.
	logic [23:0] diam_q;
	logic [6:0]  tess_q;
	logic [31:0] base_q;
	logic [15:0] xform_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q  <= 24'd131072;
			tess_q  <= 7'd8;
			base_q  <= '0;
			xform_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIAMETER: diam_q  <= cfg_data[23:0];
				REG_TESS:     tess_q  <= cfg_data[6:0];
				REG_BASE:     base_q  <= cfg_data;
				REG_XFORM:    xform_q <= cfg_data[15:0];
			endcase
		end
	end

	// Flow control.
	logic                  pipe_en;
	logic                  out_load;
	logic                  out_xfer;
	logic                  out_final;
	logic                  out_valid_q;
	logic [PIPE_DEPTH:1]   live_q;
	logic                  in_ok;
	logic [7:0]            divisor;

	assign divisor    = {tess_q, 1'b0};
	assign pipe_en    = !live_q[PIPE_DEPTH] || out_load;
	assign item_stall = !pipe_en;

	// Range check at entry; rejected items travel as bubbles.
	always_comb begin
		in_ok = (tess_q >= 7'(MIN_TESS)) && (tess_q <= 7'(MAX_TESS)) && (segment <= divisor);
		if (cmd_t'(command) == CMD_VERTEX) begin
			in_ok = in_ok && (ring <= tess_q);
		end else begin
			in_ok = in_ok && (ring < tess_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (pipe_en) begin
			live_q <= {live_q[PIPE_DEPTH-1:1], item_valid && in_ok};
		end
	end

	// Divider chain: ring and segment angles, then both texture coordinates.
	div_t       div_w [DIV_LANES][DIV_STEPS+1];
	logic [6:0] tess_less_ring;

	assign tess_less_ring = tess_q - ring;
	assign div_w[LANE_RING][0] = '{rem: '0, num: {1'b0, ring, 25'd0, tess_q}};
	assign div_w[LANE_SEG][0]  = '{rem: '0, num: {segment, 25'd0, tess_q}};
	assign div_w[LANE_TEXU][0] = '{rem: '0, num: {16'd0, segment, 9'd0, tess_q}};
	assign div_w[LANE_TEXV][0] = '{rem: '0, num: {16'd0, tess_less_ring, 10'd0, tess_q}};

	for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
		for (genvar n = 0; n < DIV_STEPS; n++) begin : g_div
			uvs_div_cell u_cell (
				.clk     (clk),
				.en      (pipe_en),
				.divisor (divisor),
				.div_in  (div_w[l][n]),
				.div_out (div_w[l][n+1])
			);
		end
	end

	// Fold angles into the right half-plane before rotating.
	logic [31:0] ang_lat;
	logic [31:0] ang_lon;
	logic        flip_lat;
	logic        flip_lon;
	logic        top_lat;
	logic        top_lon;
	rot_t        rot_lat [CORDIC_STEPS+1];
	rot_t        rot_lon [CORDIC_STEPS+1];

	always_comb begin
		ang_lat  = div_w[LANE_RING][DIV_STEPS].num[31:0] - 32'h4000_0000;
		ang_lon  = div_w[LANE_SEG][DIV_STEPS].num[31:0];
		flip_lat = ang_lat[31] ^ ang_lat[30];
		flip_lon = ang_lon[31] ^ ang_lon[30];
		top_lat  = ang_lat[31] ^ flip_lat;
		top_lon  = ang_lon[31] ^ flip_lon;
	end

	assign rot_lat[0] = '{x: CORDIC_X0, y: '0, z: $signed({top_lat, top_lat, ang_lat[30:0]})};
	assign rot_lon[0] = '{x: CORDIC_X0, y: '0, z: $signed({top_lon, top_lon, ang_lon[30:0]})};

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		uvs_cordic_cell u_lat (
			.clk     (clk),
			.en      (pipe_en),
			.step    (5'(k)),
			.rot_in  (rot_lat[k]),
			.rot_out (rot_lat[k+1])
		);
		uvs_cordic_cell u_lon (
			.clk     (clk),
			.en      (pipe_en),
			.step    (5'(k)),
			.rot_in  (rot_lon[k]),
			.rot_out (rot_lon[k+1])
		);
	end

	// Side information alongside every stage.
	side_t side_q [PIPE_DEPTH+1];
	side_t side_in;
	side_t side_div;

	always_comb begin
		side_in          = '0;
		side_in.cmd      = cmd_t'(command);
		side_in.ring     = ring;
		side_in.segment  = segment;
		side_div          = side_q[DIV_STEPS];
		side_div.tex_u    = div_w[LANE_TEXU][DIV_STEPS].num[16:0];
		side_div.tex_v    = div_w[LANE_TEXV][DIV_STEPS].num[16:0];
		side_div.flip_lat = flip_lat;
		side_div.flip_lon = flip_lon;
	end

	assign side_q[0] = side_in;

	for (genvar n = 0; n < PIPE_DEPTH; n++) begin : g_side
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				side_q[n+1] <= (n == DIV_STEPS) ? side_div : side_q[n];
			end
		end
	end

	// Stage 1: unfold sine and cosine, form the normal products.
	localparam int ROT_TAIL = DIV_STEPS + CORDIC_STEPS;

	logic signed [32:0] slat;
	logic signed [32:0] clat;
	logic signed [32:0] slon;
	logic signed [32:0] clon;
	logic signed [65:0] prod_x_s1;
	logic signed [65:0] prod_z_s1;
	logic signed [32:0] ny_s1;

	always_comb begin
		slat = side_q[ROT_TAIL].flip_lat ? -$signed(rot_lat[CORDIC_STEPS].y)
			: $signed(rot_lat[CORDIC_STEPS].y);
		clat = side_q[ROT_TAIL].flip_lat ? -$signed(rot_lat[CORDIC_STEPS].x)
			: $signed(rot_lat[CORDIC_STEPS].x);
		slon = side_q[ROT_TAIL].flip_lon ? -$signed(rot_lon[CORDIC_STEPS].y)
			: $signed(rot_lon[CORDIC_STEPS].y);
		clon = side_q[ROT_TAIL].flip_lon ? -$signed(rot_lon[CORDIC_STEPS].x)
			: $signed(rot_lon[CORDIC_STEPS].x);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			prod_x_s1 <= 66'(slon) * 66'(clat);
			prod_z_s1 <= 66'(clon) * 66'(clat);
			ny_s1     <= slat;
		end
	end

	// Stage 2: round the products back to Q2.30.
	logic signed [32:0] nx_s2;
	logic signed [32:0] ny_s2;
	logic signed [32:0] nz_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			nx_s2 <= 33'((prod_x_s1 + 66'sd536870912) >>> 30);
			nz_s2 <= 33'((prod_z_s1 + 66'sd536870912) >>> 30);
			ny_s2 <= ny_s1;
		end
	end

	// Stage 3: scale by the diameter and round the normals and tangents.
	logic signed [24:0] diam_s;
	logic signed [57:0] px_s3;
	logic signed [57:0] py_s3;
	logic signed [57:0] pz_s3;
	logic signed [15:0] nrm_x_s3;
	logic signed [15:0] nrm_y_s3;
	logic signed [15:0] nrm_z_s3;
	logic signed [15:0] tan_x_s3;
	logic signed [15:0] tan_z_s3;

	assign diam_s = $signed({1'b0, diam_q});

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			px_s3    <= 58'(nx_s2) * 58'(diam_s);
			py_s3    <= 58'(ny_s2) * 58'(diam_s);
			pz_s3    <= 58'(nz_s2) * 58'(diam_s);
			nrm_x_s3 <= to_q15(35'(nx_s2));
			nrm_y_s3 <= to_q15(35'(ny_s2));
			nrm_z_s3 <= to_q15(35'(nz_s2));
			tan_x_s3 <= to_q15(-35'(nx_s2));
			tan_z_s3 <= to_q15(-35'(nz_s2));
		end
	end

	// Quad indices from the tail's ring and segment.
	side_t       tail;
	logic [7:0]  stride;
	logic [14:0] row_off;
	logic [31:0] row0;
	logic [31:0] row1;
	logic [7:0]  seg_next;

	always_comb begin
		tail     = side_q[PIPE_DEPTH];
		stride   = {tess_q, 1'b1};
		row_off  = 15'(tail.ring) * 15'(stride);
		row0     = base_q + 32'(row_off);
		row1     = row0 + 32'(stride);
		seg_next = (tail.segment == divisor) ? 8'd0 : tail.segment + 8'd1;
	end

	// Output register; a quad stays for six transfers.
	localparam logic [2:0] LAST_SLOT = 3'(QUAD_SLOTS - 1);

	logic        quad_q;
	logic [2:0]  slot_q;
	logic [31:0] idx_a_q;
	logic [31:0] idx_b_q;
	logic [31:0] idx_c_q;
	logic [31:0] idx_d_q;

	assign out_xfer  = out_valid_q && !result_stall;
	assign out_final = !quad_q || (slot_q == LAST_SLOT);
	assign out_load  = !out_valid_q || (out_xfer && out_final);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			slot_q      <= '0;
		end else if (out_load) begin
			out_valid_q <= live_q[PIPE_DEPTH];
			slot_q      <= '0;
		end else if (out_xfer) begin
			slot_q <= slot_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			quad_q  <= (tail.cmd == CMD_QUAD);
			idx_a_q <= row0 + 32'(tail.segment);
			idx_b_q <= row1 + 32'(tail.segment);
			idx_c_q <= row0 + 32'(seg_next);
			idx_d_q <= row1 + 32'(seg_next);
			if (tail.cmd == CMD_VERTEX) begin
				pos_x <= pos_sat(px_s3);
				pos_y <= pos_sat(py_s3);
				pos_z <= pos_sat(pz_s3);
				nrm_x <= nrm_x_s3;
				nrm_y <= nrm_y_s3;
				nrm_z <= nrm_z_s3;
				tan_x <= tan_x_s3;
				tan_z <= tan_z_s3;
				tex_u <= tail.tex_u;
				tex_v <= tail.tex_v;
			end else begin
				pos_x <= '0;
				pos_y <= '0;
				pos_z <= '0;
				nrm_x <= '0;
				nrm_y <= '0;
				nrm_z <= '0;
				tan_x <= '0;
				tan_z <= '0;
				tex_u <= '0;
				tex_v <= '0;
			end
		end
	end

	// Index selection for the six triangle corners.
	always_comb begin
		index_value = '0;
		if (quad_q) begin
			case (slot_q) inside
				3'd0:       index_value = idx_a_q;
				3'd1, 3'd4: index_value = idx_b_q;
				3'd2, 3'd3: index_value = idx_c_q;
				3'd5:       index_value = idx_d_q;
				default:    index_value = '0;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign last         = out_final;

`ifndef SYNTHESIS
	// A quad never counts past its sixth slot.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (slot_q <= LAST_SLOT))
		else $error("quad slot counter out of range");

	// A live item at the pipe tail that cannot leave stays there.
	a_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(live_q[PIPE_DEPTH] && !pipe_en) |=> live_q[PIPE_DEPTH])
		else $error("pipe tail lost an item");

	// An accepted in-range item enters the first stage.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && in_ok) |=> live_q[1])
		else $error("accepted item not in first stage");

	// A non-final transfer of a quad advances the slot by one.
	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !out_final) |=> (slot_q == $past(slot_q) + 3'd1))
		else $error("quad slot did not advance");
`endif

endmodule

/* verif/tb_uv_sphere_vertex_index_generator.sv */
// Self-checking testbench for the UV sphere vertex and index generator.
// It predicts every vertex and quad index in fixed point and checks each result transfer.
// Depends on uvs_pkg and the top level uv_sphere_vertex_index_generator.
`timescale 1ns / 100ps

module tb_uv_sphere_vertex_index_generator;
	import uvs_pkg::*;

	localparam int LATENCY     = 68;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [24:0] px, py, pz;
		logic signed [15:0] nx, ny, nz, tx, tz;
		logic [16:0]        u, v;
		logic [31:0]        idx;
		logic               lst;
	} sphere_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	reg_idx_t cfg_index = REG_DIAMETER;
	logic [31:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic command = 1'b0;
	logic [6:0] ring = '0;
	logic [7:0] segment = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [24:0] pos_x, pos_y, pos_z;
	logic signed [15:0] nrm_x, nrm_y, nrm_z, tan_x, tan_z;
	logic [16:0] tex_u, tex_v;
	logic [31:0] index_value;
	logic last;

	// Predictor copy of the registers.
	logic [23:0] diam_q;
	logic [6:0]  tess_q;
	logic [31:0] base_q;
	logic [15:0] xform_q;

	sphere_out_t pending_results[$];
	int mismatches = 0;
	int cycles = 0;
	bit idle_enable = 1'b1;

	uv_sphere_vertex_index_generator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item_valid(item_valid), .item_stall(item_stall),
		.command(command), .ring(ring), .segment(segment),
		.result_valid(result_valid), .result_stall(result_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .nrm_x(nrm_x), .nrm_y(nrm_y),
		.nrm_z(nrm_z), .tan_x(tan_x), .tan_z(tan_z), .tex_u(tex_u), .tex_v(tex_v),
		.index_value(index_value), .last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Cycle limit guards against a hung pipe.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic signed [15:0] round_q15(longint v);
		return 16'(clamp(floor_shift(v + 64'sd16384, 15), -32768, 32767));
	endfunction

	function automatic logic signed [24:0] round_pos(longint n, longint d);
		return 25'(clamp(floor_shift(n * d + (64'sd1 <<< 30), 31), -16777216, 16777215));
	endfunction

	// Binary angle of n/(2T) of a turn, rounded half up.
	function automatic logic [31:0] turn_fraction(logic [31:0] n, logic [31:0] t);
		logic [63:0] num;
		num = ({32'd0, n} << 32) + 64'(t);
		return 32'(num / (64'd2 * 64'(t)));
	endfunction

	// Rotation-mode CORDIC returning sine and cosine in Q2.30.
	task automatic rotate_angle(input logic [31:0] ang, output longint s, output longint c);
		longint x, y, z, nx, ny;
		bit flip;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip) ang = ang - 32'h8000_0000;
		x = 652032874;
		y = 0;
		z = longint'($signed(ang));
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (z >= 0) begin
				nx = x - (y >>> k); ny = y + (x >>> k); z -= atan_of(5'(k));
			end else begin
				nx = x + (y >>> k); ny = y - (x >>> k); z += atan_of(5'(k));
			end
			x = nx;
			y = ny;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	// Work out the results that one item causes and queue them.
	task automatic predict_sphere_item(cmd_t cmd, logic [6:0] i, logic [7:0] j);
		sphere_out_t r;
		longint slat, clat, slon, clon, nx, ny, nz, d;
		logic [31:0] t, s, nj, row0, row1;
		logic [31:0] idx[6];
		t = 32'(tess_q);
		if (t < MIN_TESS || t > MAX_TESS || 32'(j) > 2 * t) return;
		r = '{default: '0};
		if (cmd == CMD_VERTEX) begin
			if (32'(i) > t) return;
			rotate_angle(turn_fraction(32'(i), t) - 32'h4000_0000, slat, clat);
			rotate_angle(turn_fraction(32'(j), t), slon, clon);
			d = longint'(diam_q);
			nx = floor_shift(slon * clat + (64'sd1 <<< 29), 30);
			ny = slat;
			nz = floor_shift(clon * clat + (64'sd1 <<< 29), 30);
			r.px = round_pos(nx, d);
			r.py = round_pos(ny, d);
			r.pz = round_pos(nz, d);
			r.nx = round_q15(nx);
			r.ny = round_q15(ny);
			r.nz = round_q15(nz);
			r.tx = round_q15(-nx);
			r.tz = round_q15(-nz);
			r.u = 17'((64'(j) * 65536 + 64'(t)) / (2 * 64'(t)));
			r.v = 17'((64'(t - 32'(i)) * 131072 + 64'(t)) / (2 * 64'(t)));
			r.lst = 1'b1;
			pending_results.push_back(r);
		end else begin
			if (32'(i) >= t) return;
			s = 2 * t + 1;
			nj = (32'(j) + 1) % s;
			row0 = base_q + 32'(i) * s;
			row1 = base_q + (32'(i) + 1) * s;
			idx = '{row0 + 32'(j), row1 + 32'(j), row0 + nj, row0 + nj,
				row1 + 32'(j), row1 + nj};
			for (int k = 0; k < QUAD_SLOTS; k++) begin
				r.idx = idx[k];
				r.lst = (k == QUAD_SLOTS - 1);
				pending_results.push_back(r);
			end
		end
	endtask

	// Result side: random stall and a compare of all fields on each transfer.
	always @(negedge clk) begin
		if (arst_n) result_stall <= idle_enable && ($urandom_range(99) < 21);
	end

	always @(posedge clk) begin
		sphere_out_t e;
		sphere_out_t a;
		if (arst_n && result_valid && !result_stall) begin
			a = '{pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tan_x, tan_z,
				tex_u, tex_v, index_value, last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer idx=%0d", index_value);
			end else begin
				e = pending_results.pop_front();
				if (a != e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %p act %p", e, a);
				end
			end
		end
	end

	// Write one register while the block is idle.
	task automatic write_register(reg_idx_t which, logic [31:0] value);
		item_valid <= 1'b0;
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (which)
			REG_DIAMETER: diam_q = value[23:0];
			REG_TESS:     tess_q = value[6:0];
			REG_BASE:     base_q = value;
			REG_XFORM:    xform_q = value[15:0];
			default: ;
		endcase
	endtask

	// Offer one item, with random idle cycles before it, and wait for the transfer.
	// Called at a falling edge; returns at a falling edge with the item still offered,
	// so that consecutive calls can give back-to-back transfers.
	task automatic send_sphere_item(cmd_t cmd, logic [6:0] i, logic [7:0] j);
		while (idle_enable && ($urandom_range(99) < 21)) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		ring <= i;
		segment <= j;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_sphere_item(cmd, i, j);
		@(negedge clk);
	endtask

	// Let the pipe drain completely; out-of-range items may still be in flight.
	task automatic drain_pipe();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed_extremes();
		write_register(REG_XFORM, 32'hFFFF);
		send_sphere_item(CMD_VERTEX, 7'd0, 8'd0);
		send_sphere_item(CMD_VERTEX, 7'd8, 8'd16);
		send_sphere_item(CMD_VERTEX, 7'd4, 8'd4);
		send_sphere_item(CMD_VERTEX, 7'd4, 8'd12);
		send_sphere_item(CMD_VERTEX, 7'd9, 8'd0);
		send_sphere_item(CMD_VERTEX, 7'd0, 8'd17);
		send_sphere_item(CMD_VERTEX, 7'd127, 8'd255);
		send_sphere_item(CMD_QUAD, 7'd0, 8'd0);
		send_sphere_item(CMD_QUAD, 7'd7, 8'd16);
		send_sphere_item(CMD_QUAD, 7'd8, 8'd0);
		send_sphere_item(CMD_QUAD, 7'd127, 8'd255);
		drain_pipe();
		write_register(REG_DIAMETER, 32'hFF_FFFF);
		write_register(REG_BASE, 32'hFFFF_FFF0);
		send_sphere_item(CMD_VERTEX, 7'd2, 8'd3);
		send_sphere_item(CMD_VERTEX, 7'd4, 8'd0);
		send_sphere_item(CMD_QUAD, 7'd7, 8'd15);
		drain_pipe();
		write_register(REG_DIAMETER, 32'd0);
		send_sphere_item(CMD_VERTEX, 7'd3, 8'd5);
		drain_pipe();
		// Bad tessellation values give nothing.
		write_register(REG_TESS, 32'd2);
		send_sphere_item(CMD_VERTEX, 7'd1, 8'd1);
		send_sphere_item(CMD_QUAD, 7'd0, 8'd0);
		drain_pipe();
		write_register(REG_TESS, 32'd65);
		send_sphere_item(CMD_VERTEX, 7'd1, 8'd1);
		drain_pipe();
	endtask

	// Random items over one register setting, mostly in range.
	task automatic test_random_phase(logic [6:0] t, logic [23:0] d, logic [31:0] b, int count);
		logic [6:0] i;
		logic [7:0] j;
		write_register(REG_TESS, 32'(t));
		write_register(REG_DIAMETER, 32'(d));
		write_register(REG_BASE, b);
		write_register(REG_XFORM, $urandom_range(65535));
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0) begin
				i = 7'($urandom);
				j = 8'($urandom);
			end else begin
				i = 7'($urandom_range(int'(t)));
				j = 8'($urandom_range(2 * int'(t)));
			end
			send_sphere_item(cmd_t'($urandom_range(1)), i, j);
			if (n == count / 2) begin
				// Hold the sender off until every pending result is back.
				item_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				@(negedge clk);
			end
		end
		drain_pipe();
	endtask

	task automatic test_no_idle_stretch();
		idle_enable = 1'b0;
		test_random_phase(7'd64, 24'h02_0000, 32'h1234_5678, 40);
		idle_enable = 1'b1;
	endtask

	initial begin
		diam_q = 24'd131072;
		tess_q = 7'd8;
		base_q = '0;
		xform_q = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		test_random_phase(7'd3, 24'h00_8000, 32'd0, 60);
		test_random_phase(7'd64, 24'hFF_FFFF, 32'hFFFF_FF00, 60);
		test_no_idle_stretch();
		test_random_phase(7'd13, 24'($urandom), $urandom, 80);
		test_random_phase(7'd32, 24'($urandom), $urandom, 70);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* uv_sphere_vertex_index_generator.f */
hdl/uvs_pkg.sv
hdl/uvs_div_cell.sv
hdl/uvs_cordic_cell.sv
hdl/uv_sphere_vertex_index_generator.sv
verif/tb_uv_sphere_vertex_index_generator.sv
